>>> src/gltm_pkg.sv
// ----------------------------------------------------------------------------
// gltm_pkg
// Shared types and fixed constants of the gray-level tone mapper.
// ----------------------------------------------------------------------------
package gltm_pkg;

    localparam int PIX_W     = 8;
    localparam int QUO_W     = 8;
    localparam int TAB_SIZE  = 256;
    localparam int WORK_FRAC = 48;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [1:0]       cfg_idx_t;

    localparam pix_t LEVEL_MAX_RESET = 8'd255;
    localparam pix_t LEVEL_MIN_RESET = 8'd0;
    localparam pix_t PIX_FULL        = 8'd255;

    typedef enum logic [1:0] {
        MODE_PASS    = 2'd0,
        MODE_LOG     = 2'd1,
        MODE_STRETCH = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_LEVEL_MAX = 2'd1,
        REG_LEVEL_MIN = 2'd2
    } reg_idx_t;

endpackage

>>> src/gltm_in_if.sv
// ----------------------------------------------------------------------------
// gltm_in_if
// Pixel input channel: valid, ready and one pixel word.
// ----------------------------------------------------------------------------
interface gltm_in_if;
    import gltm_pkg::*;

    logic valid;
    logic ready;
    pix_t pixel_in;
    logic end_in;

    modport source (output valid, output pixel_in, output end_in, input ready);
    modport sink (input valid, input pixel_in, input end_in, output ready);

endinterface

>>> src/gltm_out_if.sv
// ----------------------------------------------------------------------------
// gltm_out_if
// Pixel result channel: valid, ready and one mapped pixel word.
// ----------------------------------------------------------------------------
interface gltm_out_if;
    import gltm_pkg::*;

    logic valid;
    logic ready;
    pix_t pixel_out;
    logic end_out;

    modport source (output valid, output pixel_out, output end_out, input ready);
    modport sink (input valid, input pixel_out, input end_out, output ready);

endinterface

>>> src/gltm_cfg_if.sv
// ----------------------------------------------------------------------------
// gltm_cfg_if
// Configuration write channel: valid, ready, register index and data word.
// ----------------------------------------------------------------------------
interface gltm_cfg_if;
    import gltm_pkg::*;

    logic     valid;
    logic     ready;
    cfg_idx_t index;
    pix_t     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

>>> src/gray_level_tone_mapper_unit.sv
// ----------------------------------------------------------------------------
// gray_level_tone_mapper_unit
// Pipeline: 12 register stages; front, scale, nine divider steps and the output register.
// Throughput: one pixel per clock unless the result side stalls; all stages pipeline.
// A stall on the result side freezes every stage at once and drops nothing.
// Reset clears all stage valid bits and loads mode 0, level_max 255, level_min 0.
// ----------------------------------------------------------------------------
module gray_level_tone_mapper_unit #(
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    gltm_in_if.sink  feed,
    gltm_out_if.source result,
    gltm_cfg_if.sink cfg
);
    import gltm_pkg::*;

    // Table entries reach log2(256) = 8, so four integer bits are needed.
    localparam int LW      = LOG_FRAC_BITS + 4;
    localparam int NW      = LW + QUO_W;
    localparam int DIV_STG = QUO_W + 1;

    typedef struct packed {
        logic          eoi;
        pix_t          pix;
        logic          pass;
        logic          zero;
        logic [LW-1:0] a;
        logic [LW-1:0] den;
    } front_t;

    typedef struct packed {
        logic             eoi;
        pix_t             pix;
        logic             pass;
        logic             zero;
        logic             sat;
        logic [QUO_W-1:0] quo;
        logic [NW-1:0]    rem;
        logic [LW-1:0]    den;
    } stage_t;

    // round(log2(n) * 2^LOG_FRAC_BITS), from repeated squaring of a Q62 mantissa.
    function automatic logic [63:0] fixed_log2(input int unsigned n);
        logic [63:0]  e;
        logic [63:0]  m;
        logic [63:0]  frac;
        logic [63:0]  r;
        logic [127:0] sq;
        int           i;
        e    = 64'd0;
        frac = 64'd0;
        for (i = 0; i < 8; i++)
        begin
            if ((n >> (i + 1)) != 0)
            begin
                e = 64'(i + 1);
            end
        end
        m = 64'(n) << (62 - e);
        for (i = 0; i < WORK_FRAC; i++)
        begin
            sq   = {64'd0, m} * {64'd0, m};
            m    = sq[125:62];
            frac = {frac[62:0], 1'b0};
            if (m[63])
            begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        r = (e << WORK_FRAC) | frac;
        r = r + (64'd1 << (WORK_FRAC - LOG_FRAC_BITS - 1));
        return r >> (WORK_FRAC - LOG_FRAC_BITS);
    endfunction

    // One restoring step; the top step only flags a quotient above 255.
    function automatic stage_t div_step(input stage_t cur, input int unsigned sh);
        stage_t        nxt;
        logic [NW-1:0] part;
        nxt  = cur;
        part = NW'(cur.den) << sh;
        if (sh == QUO_W)
        begin
            nxt.sat = (cur.rem >= part);
        end
        else if (cur.rem >= part)
        begin
            nxt.rem         = cur.rem - part;
            nxt.quo[sh[2:0]] = 1'b1;
        end
        return nxt;
    endfunction

    logic [LW-1:0] log_tab [TAB_SIZE];

    for (genvar g = 0; g < TAB_SIZE; g++)
    begin : g_log_tab
        localparam logic [63:0] ENTRY = fixed_log2(g + 1);
        assign log_tab[g] = ENTRY[LW-1:0];
    end

    // Configuration registers.
    mode_t mode_reg;
    pix_t  level_max_reg;
    pix_t  level_min_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_PASS;
            level_max_reg <= LEVEL_MAX_RESET;
            level_min_reg <= LEVEL_MIN_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MODE:      mode_reg      <= mode_t'(cfg.data[1:0]);
                REG_LEVEL_MAX: level_max_reg <= cfg.data;
                REG_LEVEL_MIN: level_min_reg <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Pipeline control: the whole pipe advances whenever the output register is free.
    logic   adv;
    logic   front_vld_reg;
    front_t front_reg;
    front_t front_next;
    logic   stg_vld_reg [DIV_STG+1];
    stage_t stage_reg [DIV_STG+1];
    stage_t stage_next [DIV_STG+1];
    logic   out_vld_reg;
    pix_t   out_pix_reg;
    pix_t   out_pix_next;
    logic   out_eoi_reg;
    pix_t   clamped;
    stage_t last;

    assign adv        = !out_vld_reg || result.ready;
    assign feed.ready = adv;

    // Front stage: table lookups or clamped differences, plus the special cases.
    always_comb
    begin
        if (feed.pixel_in < level_min_reg)
        begin
            clamped = level_min_reg;
        end
        else if (feed.pixel_in > level_max_reg)
        begin
            clamped = level_max_reg;
        end
        else
        begin
            clamped = feed.pixel_in;
        end

        front_next.eoi = feed.end_in;
        front_next.pix = feed.pixel_in;
        case (mode_reg)
            MODE_LOG:
            begin
                front_next.pass = 1'b0;
                front_next.zero = (level_max_reg == '0);
                front_next.a    = log_tab[feed.pixel_in];
                front_next.den  = log_tab[level_max_reg];
            end
            MODE_STRETCH:
            begin
                front_next.pass = 1'b0;
                front_next.zero = (level_max_reg <= level_min_reg);
                front_next.a    = LW'(clamped - level_min_reg);
                front_next.den  = LW'(level_max_reg - level_min_reg);
            end
            default:
            begin
                front_next.pass = 1'b1;
                front_next.zero = 1'b0;
                front_next.a    = '0;
                front_next.den  = LW'(1);
            end
        endcase
    end

    // Scale stage builds the dividend as a*255 = a*256 - a; the rest are divider steps.
    always_comb
    begin
        stage_next[0].eoi  = front_reg.eoi;
        stage_next[0].pix  = front_reg.pix;
        stage_next[0].pass = front_reg.pass;
        stage_next[0].zero = front_reg.zero;
        stage_next[0].sat  = 1'b0;
        stage_next[0].quo  = '0;
        stage_next[0].rem  = {front_reg.a, {QUO_W{1'b0}}} - NW'(front_reg.a);
        stage_next[0].den  = front_reg.den;
        for (int k = 0; k < DIV_STG; k++)
        begin
            stage_next[k+1] = div_step(stage_reg[k], QUO_W - k);
        end
    end

    assign last = stage_reg[DIV_STG];

    always_comb
    begin
        if (last.pass)
        begin
            out_pix_next = last.pix;
        end
        else if (last.zero)
        begin
            out_pix_next = '0;
        end
        else if (last.sat)
        begin
            out_pix_next = PIX_FULL;
        end
        else
        begin
            out_pix_next = last.quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= 1'b0;
            for (int k = 0; k <= DIV_STG; k++)
            begin
                stg_vld_reg[k] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            front_vld_reg  <= feed.valid;
            stg_vld_reg[0] <= front_vld_reg;
            for (int k = 1; k <= DIV_STG; k++)
            begin
                stg_vld_reg[k] <= stg_vld_reg[k-1];
            end
            out_vld_reg <= stg_vld_reg[DIV_STG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg <= front_next;
            for (int k = 0; k <= DIV_STG; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
            out_pix_reg <= out_pix_next;
            out_eoi_reg <= last.eoi;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.pixel_out = out_pix_reg;
    assign result.end_out   = out_eoi_reg;

`ifndef ASSERT_OFF
    // A clamped stretch never yields a quotient above 255.
    a_stretch_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        stg_vld_reg[DIV_STG] && !last.pass && !last.zero && mode_reg == MODE_STRETCH
        |-> !last.sat)
        else $error("stretch quotient overflowed");

    // A pixel at or below level_max keeps the log quotient within range.
    a_log_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        stg_vld_reg[DIV_STG] && !last.pass && !last.zero && mode_reg == MODE_LOG
        && last.pix <= level_max_reg |-> !last.sat)
        else $error("log quotient overflowed for an in-range pixel");

    // After the last step the remainder is below the divisor.
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        stg_vld_reg[DIV_STG] && !last.pass && !last.zero && !last.sat
        |-> last.rem < NW'(last.den))
        else $error("divider remainder not reduced");

    // A word leaving the divider reaches the output register on the next edge.
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        stg_vld_reg[DIV_STG] && adv |=> out_vld_reg && out_pix_reg == $past(out_pix_next))
        else $error("result word lost at the output register");
`endif

endmodule
